### hdl/stl_pkg.sv
// shared types and constants for the slot table rank lookup block
package stl_pkg;

	localparam int SLOTS    = 64;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int RANK_W   = 6;
	localparam int OCC_W    = 7;
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 48;

	typedef enum logic [OP_W-1:0] {
		OP_ADD         = 3'd0,
		OP_REMOVE      = 3'd1,
		OP_GET_BY_RANK = 3'd2,
		OP_RANK_OF     = 3'd3,
		OP_COUNT       = 3'd4
	} req_op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic imm;
		logic scan;
	} stl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic hit;
		logic miss_end;
	} stl_sts_t;

endpackage

### hdl/slot_table_rank_lookup.sv
// count, zero key or unknown requests skip the scan and go from S_CHECK straight to S_DONE
// scanning requests read one slot per cycle until a hit or the last slot, then go to S_DONE
// throughput: one request at a time, next word taken in the cycle after the result leaves
// the scan rate is set by the single read port of the key memory
// reset: asynchronous, clears all occupancy bits and the count, table reads as empty at once
// top level of the slot table rank lookup block
module slot_table_rank_lookup import stl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // key, rank, zero pad
	input  logic [OP_W-1:0]  s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // found_key, found_rank, occupied, zero pad
	output logic [ST_W-1:0]  m_tuser   // status
);

	stl_cmd_t            cmd;
	stl_sts_t            sts;
	status_t             status;
	logic [KEY_BITS-1:0] found_key;
	logic [RANK_W-1:0]   found_rank;
	logic [OCC_W-1:0]    occupied;

	stl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	stl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (s_tuser),
		.key        (s_tdata[KEY_BITS-1:0]),
		.rank       (s_tdata[KEY_BITS+RANK_W-1:KEY_BITS]),
		.status     (status),
		.found_key  (found_key),
		.found_rank (found_rank),
		.occupied   (occupied)
	);

	assign m_tuser = status;
	assign m_tdata = {(OUT_W - KEY_BITS - RANK_W - OCC_W)'(0), occupied, found_rank, found_key};

endmodule

### hdl/stl_ctrl.sv
// controller state machine sequencing request capture, slot scan and result hand-off
module stl_ctrl import stl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output stl_cmd_t cmd,
	input  stl_sts_t sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.need_scan) begin
					state_d = S_SCAN;
				end else begin
					cmd.imm = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.miss_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/stl_dp.sv
// datapath: key memory, occupancy bits, scan pipeline, counters and result registers
module stl_dp import stl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  stl_cmd_t            cmd,
	output stl_sts_t            sts,
	input  logic [OP_W-1:0]     req_type,
	input  logic [KEY_BITS-1:0] key,
	input  logic [RANK_W-1:0]   rank,
	output status_t             status,
	output logic [KEY_BITS-1:0] found_key,
	output logic [RANK_W-1:0]   found_rank,
	output logic [OCC_W-1:0]    occupied
);

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [RANK_W-1:0]   rank_q;

	logic [KEY_BITS-1:0] key_mem_q [SLOTS];
	logic [SLOTS-1:0]    valid_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    seen_q;

	logic [IDX_W-1:0]    addr_q;
	logic                more_q;
	logic                act_s1;
	logic                last_s1;
	logic                vld_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [IDX_W-1:0]    idx_s1;

	status_t             status_q;
	logic [KEY_BITS-1:0] fkey_q;
	logic [RANK_W-1:0]   frank_q;

	logic    key_zero;
	logic    match;
	logic    hit_raw;
	logic    eval;
	logic    wr_en;
	logic    need_scan;
	logic    scan_hit;
	logic    scan_miss;
	status_t imm_status;

	assign key_zero = (key_q == '0);
	assign match    = vld_s1 && (key_s1 == key_q);
	assign eval     = cmd.scan && act_s1;

	always_comb begin
		need_scan  = 1'b0;
		hit_raw    = 1'b0;
		imm_status = ST_MISS;
		unique case (op_q)
			OP_ADD: begin
				need_scan  = !key_zero;
				hit_raw    = !vld_s1;
				imm_status = ST_ZERO;
			end
			OP_REMOVE, OP_RANK_OF: begin
				need_scan  = !key_zero;
				hit_raw    = match;
				imm_status = ST_ZERO;
			end
			OP_GET_BY_RANK: begin
				need_scan = 1'b1;
				hit_raw   = vld_s1 && (seen_q == CNT_W'(rank_q));
			end
			OP_COUNT: begin
				imm_status = ST_OK;
			end
			default: begin
				imm_status = ST_MISS;
			end
		endcase
	end

	assign scan_hit  = eval && hit_raw;
	assign scan_miss = eval && last_s1 && !hit_raw;
	assign sts       = '{need_scan: need_scan, hit: scan_hit, miss_end: scan_miss};
	assign wr_en     = sts.hit && (op_q == OP_ADD);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_type;
			key_q  <= key;
			rank_q <= rank;
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem_q[idx_s1] <= key_q;
		end
		key_s1 <= key_mem_q[addr_q];
	end

	always_ff @(posedge clk) begin
		vld_s1  <= valid_q[addr_q];
		idx_s1  <= addr_q;
		last_s1 <= (addr_q == IDX_W'(SLOTS - 1));
	end

	// scan address issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			more_q <= 1'b0;
			act_s1 <= 1'b0;
		end else if (cmd.load) begin
			addr_q <= '0;
			more_q <= 1'b1;
			act_s1 <= 1'b0;
		end else if (cmd.scan) begin
			act_s1 <= more_q;
			if (more_q) begin
				addr_q <= addr_q + 1'b1;
				more_q <= (addr_q != IDX_W'(SLOTS - 1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.load) begin
			seen_q <= '0;
		end else if (eval && vld_s1 && !hit_raw) begin
			seen_q <= seen_q + 1'b1;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (sts.hit) begin
			if (op_q == OP_ADD) begin
				valid_q[idx_s1] <= 1'b1;
				used_q          <= used_q + 1'b1;
			end else if (op_q == OP_REMOVE) begin
				valid_q[idx_s1] <= 1'b0;
				if (used_q != '0) begin
					used_q <= used_q - 1'b1;
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.imm) begin
			status_q <= imm_status;
			fkey_q   <= '0;
			frank_q  <= '0;
		end else if (sts.hit) begin
			status_q <= ST_OK;
			fkey_q   <= (op_q == OP_GET_BY_RANK) ? key_s1 : '0;
			frank_q  <= (op_q == OP_RANK_OF) ? seen_q[RANK_W-1:0] : '0;
		end else if (sts.miss_end) begin
			status_q <= (op_q == OP_ADD) ? ST_FULL : ST_MISS;
			fkey_q   <= '0;
			frank_q  <= '0;
		end
	end

	assign status     = status_q;
	assign found_key  = fkey_q;
	assign found_rank = frank_q;
	assign occupied   = OCC_W'(used_q);

endmodule

### hdl/stl_checker.sv
// port-level checks for the slot table rank lookup block
module stl_checker import stl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [ST_W-1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("request not held for processing");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[44:38] <= 7'(SLOTS))
		else $error("occupied count beyond capacity");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata[37:0] == '0)
		else $error("failed request carries a key or rank");

endmodule

bind slot_table_rank_lookup stl_checker u_stl_checker (.*);

### sim/slot_table_rank_lookup_test.sv
// self-checking stream testbench for the slot table rank lookup block
module slot_table_rank_lookup_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stl_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
	localparam int MAX_WAIT = 13;

	typedef struct {
		status_t              status;
		logic [KEY_BITS-1:0]  found_key;
		logic [RANK_W-1:0]    found_rank;
		logic [OCC_W-1:0]     occupied;
	} lookup_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]  s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [ST_W-1:0]  m_tuser;

	logic [KEY_BITS-1:0] slot_key [SLOTS];
	logic [OCC_W-1:0]    used_slots = '0;
	int                  peak_used = 0;
	lookup_result_t      pending_results [$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int hold_len = 0;
	int errors = 0;
	int op_count [8];
	int status_count [4];

	slot_table_rank_lookup u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic lookup_result_t apply_request(logic [OP_W-1:0] op,
			logic [KEY_BITS-1:0] key, logic [RANK_W-1:0] rank);
		lookup_result_t r;
		int seen;
		bit done;
		r.status = ST_OK;
		r.found_key = '0;
		r.found_rank = '0;
		seen = 0;
		done = 1'b0;
		case (op)
			OP_ADD: begin
				if (key == '0) begin
					r.status = ST_ZERO;
				end else begin
					r.status = ST_FULL;
					for (int i = 0; i < SLOTS && !done; i++) begin
						if (slot_key[i] == '0) begin
							slot_key[i] = key;
							used_slots++;
							r.status = ST_OK;
							done = 1'b1;
						end
					end
				end
			end
			OP_REMOVE: begin
				if (key == '0) begin
					r.status = ST_ZERO;
				end else begin
					r.status = ST_MISS;
					for (int i = 0; i < SLOTS && !done; i++) begin
						if (slot_key[i] == key) begin
							slot_key[i] = '0;
							if (used_slots > 0) used_slots--;
							r.status = ST_OK;
							done = 1'b1;
						end
					end
				end
			end
			OP_GET_BY_RANK: begin
				r.status = ST_MISS;
				for (int i = 0; i < SLOTS && !done; i++) begin
					if (slot_key[i] != '0) begin
						if (seen == int'(rank)) begin
							r.status = ST_OK;
							r.found_key = slot_key[i];
							done = 1'b1;
						end
						seen++;
					end
				end
			end
			OP_RANK_OF: begin
				if (key == '0) begin
					r.status = ST_ZERO;
				end else begin
					r.status = ST_MISS;
					for (int i = 0; i < SLOTS && !done; i++) begin
						if (slot_key[i] == key) begin
							r.status = ST_OK;
							r.found_rank = seen[RANK_W-1:0];
							done = 1'b1;
						end else if (slot_key[i] != '0) begin
							seen++;
						end
					end
				end
			end
			OP_COUNT: r.status = ST_OK;
			default: r.status = ST_MISS;
		endcase
		r.occupied = used_slots;
		if (int'(used_slots) > peak_used) peak_used = int'(used_slots);
		return r;
	endfunction

	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
			logic [RANK_W-1:0] rank);
		int gap;
		lookup_result_t r;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, rank, key};
		s_tuser = op;
		do @(posedge clk); while (!s_tready);
		r = apply_request(op, key, rank);
		pending_results.push_back(r);
		op_count[op]++;
		status_count[r.status]++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic logic [KEY_BITS-1:0] any_nonzero_key();
		logic [KEY_BITS-1:0] k;
		do k = $urandom; while (k == '0);
		return k;
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		int r;
		int idx;
		r = $urandom_range(0, 99);
		idx = $urandom_range(0, SLOTS - 1);
		if (r < 40 && slot_key[idx] != '0) return slot_key[idx];
		if (r < 70) return KEY_BITS'($urandom_range(1, 12));
		if (r < 95) return any_nonzero_key();
		return '0;
	endfunction

	// result sink: random stalls, plus a long hold when a test asks for one
	always begin : result_sink
		int pause;
		@(negedge clk);
		if (hold_len > 0) begin
			pause = hold_len;
			hold_len = 0;
		end else begin
			pause = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		end
		if (pause > 0) begin
			m_tready = 1'b0;
			repeat (pause) @(negedge clk);
		end
		m_tready = 1'b1;
		do @(posedge clk); while (!m_tvalid);
	end

	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no request pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata[31:0] !== want.found_key) begin
					$error("found_key: expected %h, got %h", want.found_key, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[37:32] !== want.found_rank) begin
					$error("found_rank: expected %0d, got %0d", want.found_rank,
						m_tdata[37:32]);
					errors++;
				end
				if (m_tdata[44:38] !== want.occupied) begin
					$error("occupied: expected %0d, got %0d", want.occupied, m_tdata[44:38]);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_request(OP_COUNT, 32'h0, 6'd0);
		send_request(OP_GET_BY_RANK, 32'h0, 6'd0);
		send_request(OP_RANK_OF, 32'h5, 6'd0);
		send_request(OP_REMOVE, 32'h5, 6'd0);
		send_request(OP_ADD, 32'h0, 6'd63);
		send_request(OP_REMOVE, 32'h0, 6'd0);
		send_request(OP_RANK_OF, 32'h0, 6'd0);
		send_request(OP_RESERVED_LO, 32'hFFFF_FFFF, 6'd63);
		send_request(OP_RESERVED_HI, 32'h1, 6'd1);
		send_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
		send_request(OP_ADD, 32'h1, 6'd0);
		send_request(OP_ADD, 32'h1, 6'd0);
		send_request(OP_ADD, 32'h8000_0000, 6'd0);
		send_request(OP_RANK_OF, 32'h1, 6'd0);
		send_request(OP_GET_BY_RANK, 32'h0, 6'd3);
		send_request(OP_GET_BY_RANK, 32'h0, 6'd4);
		send_request(OP_GET_BY_RANK, 32'hFFFF_FFFF, 6'd63);
		send_request(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
		send_request(OP_RANK_OF, 32'h1, 6'd0);
		send_request(OP_ADD, 32'h2, 6'd0);
		send_request(OP_RANK_OF, 32'h8000_0000, 6'd0);
		send_request(OP_REMOVE, 32'h1, 6'd0);
		send_request(OP_REMOVE, 32'h1, 6'd0);
		send_request(OP_REMOVE, 32'h1, 6'd0);
		send_request(OP_COUNT, 32'h0, 6'd0);
	endtask

	task automatic test_full_table();
		logic [KEY_BITS-1:0] k;
		while (int'(used_slots) < SLOTS) send_request(OP_ADD, any_nonzero_key(), 6'($urandom));
		send_request(OP_ADD, any_nonzero_key(), 6'd0);
		send_request(OP_GET_BY_RANK, 32'h0, 6'd63);
		k = slot_key[SLOTS - 1];
		send_request(OP_RANK_OF, k, 6'd0);
		send_request(OP_REMOVE, slot_key[SLOTS / 2], 6'd0);
		send_request(OP_GET_BY_RANK, 32'h0, 6'd63);
		send_request(OP_ADD, any_nonzero_key(), 6'd0);
		send_request(OP_ADD, any_nonzero_key(), 6'd0);
		send_request(OP_COUNT, 32'h0, 6'd0);
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		hold_len = 300;
		repeat (10) send_request(OP_RANK_OF, pick_key(), 6'($urandom));
		tx_idle = 1'b1;
	endtask

	task automatic test_random(int n, int add_w, int rem_w);
		int r;
		logic [OP_W-1:0] op;
		logic [RANK_W-1:0] rank;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < add_w) op = OP_ADD;
			else if (r < add_w + rem_w) op = OP_REMOVE;
			else if (r < 98) op = OP_GET_BY_RANK + OP_W'($urandom_range(0, 2));
			else op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
			if (op == OP_GET_BY_RANK && $urandom_range(0, 3) != 0)
				rank = RANK_W'($urandom_range(0, int'(used_slots)));
			else
				rank = RANK_W'($urandom);
			send_request(op, pick_key(), rank);
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) slot_key[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_backpressure();
		test_random(40, 15, 55);
		test_random(90, 60, 15);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random(50, 30, 30);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_random(70, 15, 50);
		test_random(50, 30, 30);
		stop_sending();

		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered add %0d, remove %0d, get-by-rank %0d, rank-of %0d, count %0d, reserved %0d",
			op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_GET_BY_RANK],
			op_count[OP_RANK_OF], op_count[OP_COUNT],
			op_count[5] + op_count[6] + op_count[7]);
		$display("statuses ok %0d, miss %0d, full %0d, zero key %0d; peak occupancy %0d",
			status_count[ST_OK], status_count[ST_MISS], status_count[ST_FULL],
			status_count[ST_ZERO], peak_used);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
hdl/stl_pkg.sv
hdl/stl_ctrl.sv
hdl/stl_dp.sv
hdl/slot_table_rank_lookup.sv
hdl/stl_checker.sv
sim/slot_table_rank_lookup_test.sv
